### rtl/rsc_pkg.sv
// Shared constants, types and helpers of the radix string converter.
// No dependencies; every other file imports this package.
package rsc_pkg;

  localparam int VALUE_BITS = 31;
  localparam int MAX_RADIX  = 16;
  localparam int SYM_W      = 8;
  localparam int DIGIT_W    = 4;
  localparam int RADIX_W    = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int ALPH_W     = MAX_RADIX * SYM_W;
  localparam int DIG_IDX_W  = $clog2(VALUE_BITS + 1);
  localparam int CNT_W      = DIG_IDX_W + 1;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

  localparam logic [SYM_W-1:0]   SIGN_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]   SIGN_MINUS = 8'h2D;
  localparam logic [RADIX_W-1:0] MIN_RADIX  = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX    = 2'd0,
    CFG_ALPH_LOW = 2'd1,
    CFG_ALPH_HI  = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_RD    = 6'b001000,
    S_LD    = 6'b010000,
    S_ERR   = 6'b100000
  } state_t;

  function automatic logic [SYM_W-1:0] symbol_of(input logic [ALPH_W-1:0] alph,
                                                 input logic [DIGIT_W-1:0] d);
    return alph[{d, 3'b000} +: SYM_W];
  endfunction

endpackage

### rtl/rsc_if.sv
// Channel interfaces of the radix string converter: input, result, config.
// Depends on rsc_pkg.
interface rsc_in_if;
  import rsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] number;
  modport source (output valid, number, input ready);
  modport sink   (input valid, number, output ready);
endinterface

interface rsc_out_if;
  import rsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic             base_error;
  modport source (output valid, symbol, last, base_error, input ready);
  modport sink   (input valid, symbol, last, base_error, output ready);
endinterface

interface rsc_cfg_if;
  import rsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/radix_string_converter_top.sv
// Radix string converter top level: alphabet check, bit-serial divider,
// digit store and output register. Depends on rsc_pkg and rsc_if.sv.
//
// Usage: one word on in_ch carries a non-negative number. The block answers
// with one word per character on out_ch, most significant digit first, the
// final word marked by last. Zero gives the symbol of digit value 0 alone.
// A bad radix or alphabet (radix outside 2..16, a sign byte or a repeated
// byte among the symbols in use) gives one word with base_error set,
// symbol 0 and last set. cfg_ch writes radix, alphabet_low, alphabet_high at
// indexes 0, 1, 2; other indexes are dropped. cfg_ch is always ready.
// cfg_ch must be written only while the block is idle; the block itself does
// not enforce it. The block takes one item at a time. After accept, the
// alphabet check steps through the radix symbols in use (one symbol compared
// against the later ones per cycle), then each digit comes from the restoring
// divider (one quotient bit per cycle). Each digit is emitted by a registered
// digit store read, then a load of the output register. The error state, which
// loads the error word, follows accept directly for a bad radix and the check
// of the first bad symbol for a bad alphabet. in_ch.ready rises again once the
// last word sits in the output register. A stalled receiver holds the output
// register and the sequencer waits. Reset clears the configuration to zero.
module radix_string_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  rsc_in_if.sink      in_ch,
  rsc_out_if.source   out_ch,
  rsc_cfg_if.sink     cfg_ch
);
  import rsc_pkg::*;

  state_t                 state_r, state_nxt;
  logic [RADIX_W-1:0]     radix_r;
  logic [CFG_DATA_W-1:0]  alph_low_r, alph_high_r;
  logic [ALPH_W-1:0]      alph;

  logic [VALUE_BITS-1:0]  quo_r, quo_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIGIT_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]       digit_cnt_r, digit_cnt_nxt;
  logic [DIG_IDX_W-1:0]   emit_idx_r, emit_idx_nxt;

  logic [DIGIT_W-1:0]     digit_mem [VALUE_BITS+1];
  logic [DIGIT_W-1:0]     rd_data_r;
  logic                   mem_we;

  logic                   out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]       out_symbol_r, out_symbol_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_err_r, out_err_nxt;
  logic                   out_free, out_load;

  logic [SYM_W-1:0]       sym_cur;
  logic                   chk_bad, chk_last;
  logic [RADIX_W-1:0]     div_trial;
  logic                   div_ge;
  logic [DIGIT_W-1:0]     rem_step;
  logic [VALUE_BITS-1:0]  quo_step;
  logic                   in_acc;

  assign alph         = {alph_high_r, alph_low_r};
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.symbol     = out_symbol_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.base_error = out_err_r;
  assign out_free          = !out_valid_r || out_ch.ready;

  // alphabet check: one symbol against all later symbols in use
  always_comb begin
    sym_cur = symbol_of(alph, chk_idx_r);
    chk_bad = (sym_cur == SIGN_PLUS) || (sym_cur == SIGN_MINUS);
    for (int j = 0; j < MAX_RADIX; j++) begin
      if ((RADIX_W'(j) > {1'b0, chk_idx_r}) && (RADIX_W'(j) < radix_r) &&
          (symbol_of(alph, DIGIT_W'(j)) == sym_cur)) begin
        chk_bad = 1'b1;
      end
    end
  end
  assign chk_last = ({1'b0, chk_idx_r} == (radix_r - RADIX_W'(1)));

  // restoring divider step
  assign div_trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign div_ge    = (div_trial >= radix_r);
  assign rem_step  = div_ge ? DIGIT_W'(div_trial - radix_r) : div_trial[DIGIT_W-1:0];
  assign quo_step  = {quo_r[VALUE_BITS-2:0], div_ge};

  always_comb begin
    state_nxt      = state_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    bit_cnt_nxt    = bit_cnt_r;
    chk_idx_nxt    = chk_idx_r;
    digit_cnt_nxt  = digit_cnt_r;
    emit_idx_nxt   = emit_idx_r;
    mem_we         = 1'b0;
    out_load       = 1'b0;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          quo_nxt       = in_ch.number;
          rem_nxt       = '0;
          bit_cnt_nxt   = '0;
          chk_idx_nxt   = '0;
          digit_cnt_nxt = '0;
          if (radix_r < MIN_RADIX || radix_r > RADIX_W'(MAX_RADIX)) begin
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        chk_idx_nxt = chk_idx_r + DIGIT_W'(1);
        if (chk_bad) begin
          state_nxt = S_ERR;
        end else if (chk_last) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        quo_nxt     = quo_step;
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(VALUE_BITS - 1)) begin
          mem_we        = 1'b1;
          digit_cnt_nxt = digit_cnt_r + CNT_W'(1);
          rem_nxt       = '0;
          bit_cnt_nxt   = '0;
          if (quo_step == '0) begin
            emit_idx_nxt = digit_cnt_r[DIG_IDX_W-1:0];
            state_nxt    = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_symbol_nxt = symbol_of(alph, rd_data_r);
          out_last_nxt   = (emit_idx_r == '0);
          out_err_nxt    = 1'b0;
          if (emit_idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r - DIG_IDX_W'(1);
            state_nxt    = S_RD;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_symbol_nxt = '0;
          out_last_nxt   = 1'b1;
          out_err_nxt    = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      radix_r     <= '0;
      alph_low_r  <= '0;
      alph_high_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_RADIX:    radix_r     <= cfg_ch.data[RADIX_W-1:0];
          CFG_ALPH_LOW: alph_low_r  <= cfg_ch.data;
          CFG_ALPH_HI:  alph_high_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    digit_cnt_r  <= digit_cnt_nxt;
    emit_idx_r   <= emit_idx_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[digit_cnt_r[DIG_IDX_W-1:0]] <= rem_step;
    end
    rd_data_r <= digit_mem[emit_idx_r];
  end

endmodule
